[rtl/sgah_pkg.sv]
// shared types and constants for the sorted group aggregate block
// function, operator and register index codes, lane and config structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sgah_pkg;

    localparam int IN_COLUMNS = 3;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 64;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    // aggregate function codes
    localparam logic [2:0] FUNC_MAX   = 3'd0;
    localparam logic [2:0] FUNC_MIN   = 3'd1;
    localparam logic [2:0] FUNC_COUNT = 3'd2;
    localparam logic [2:0] FUNC_SUM   = 3'd3;
    localparam logic [2:0] FUNC_AVG   = 3'd4;

    // compare operator codes
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_NE = 3'd1;
    localparam logic [2:0] OP_GT = 3'd2;
    localparam logic [2:0] OP_GE = 3'd3;
    localparam logic [2:0] OP_LT = 3'd4;
    localparam logic [2:0] OP_LE = 3'd5;

    // right side column code that selects the constant
    localparam logic [2:0] RHS_CONST_COL = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_LHS_FUNC  = 3'd0;
    localparam logic [2:0] CFG_LHS_COL   = 3'd1;
    localparam logic [2:0] CFG_OP        = 3'd2;
    localparam logic [2:0] CFG_RHS_FUNC  = 3'd3;
    localparam logic [2:0] CFG_RHS_COL   = 3'd4;
    localparam logic [2:0] CFG_RHS_VALUE = 3'd5;
    localparam logic [2:0] CFG_RET_FUNC  = 3'd6;
    localparam logic [2:0] CFG_RET_COL   = 3'd7;

    typedef struct packed {
        logic [2:0]               lhs_func;
        logic [1:0]               lhs_col;
        logic [2:0]               op;
        logic [2:0]               rhs_func;
        logic [2:0]               rhs_col;
        logic signed [DATA_W-1:0] rhs_value;
        logic [2:0]               ret_func;
        logic [1:0]               ret_col;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic acc;
    } lane_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0]         sum;
        logic signed [DATA_W-1:0] mn;
        logic signed [DATA_W-1:0] mx;
    } lane_agg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [SUM_W-1:0]         sum;
        logic                     div;
    } opnd_t;

    typedef enum logic [1:0] {
        CL_IDLE,
        CL_SCAN,
        CL_DIV,
        CL_DECIDE
    } close_state_t;

endpackage

`default_nettype wire

[rtl/sgah_lane.sv]
// one value column accumulator: wrapping 64-bit sum, minimum and maximum
// depends on sgah_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgah_lane (
    input  wire                              clk,
    input  wire                              rst_n,
    input  sgah_pkg::lane_ctl_t              ctl,
    input  wire logic signed [31:0]          value,
    output sgah_pkg::lane_agg_t              agg
);
    import sgah_pkg::*;

    lane_agg_t agg_reg;
    lane_agg_t agg_next;
    lane_agg_t base;

    always_comb
    begin
        // a new group starts from the empty values and may take this beat at once
        base = ctl.clear ? '{sum: '0, mn: INT_MAX, mx: INT_MIN} : agg_reg;
        agg_next = base;
        if (ctl.acc)
        begin
            agg_next.sum = base.sum + {{(SUM_W-DATA_W){value[DATA_W-1]}}, value};
            if (value < base.mn)
            begin
                agg_next.mn = value;
            end
            if (value > base.mx)
            begin
                agg_next.mx = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_reg <= '{sum: '0, mn: INT_MAX, mx: INT_MIN};
        end
        else
        begin
            agg_reg <= agg_next;
        end
    end

    assign agg = agg_reg;

endmodule

`default_nettype wire

[rtl/sgah_div.sv]
// iterative signed 64-bit by unsigned 32-bit divider, one quotient bit per cycle
// returns the low 32 bits of the truncated quotient, 0 for a zero divisor
// depends on sgah_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgah_div (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire  [63:0]              dividend,
    input  wire  [31:0]              divisor,
    output logic                     done,
    output logic [31:0]              quotient
);
    import sgah_pkg::*;

    localparam int STEPS  = SUM_W;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsr_reg;

    logic [DATA_W:0]   shifted;
    logic              ge;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            zero_reg <= (divisor == '0);
            quo_reg  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops
            rem_reg <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

    assign done = done_reg;

    always_comb
    begin
        if (zero_reg)
        begin
            quotient = '0;
        end
        else if (neg_reg)
        begin
            quotient = ~quo_reg[DATA_W-1:0] + 1'b1;
        end
        else
        begin
            quotient = quo_reg[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/sgah_close.sv]
// group close unit: merges the lane results into the three operands,
// runs averages through the shared divider, applies the filter, holds the result
// depends on sgah_pkg and sgah_div
`timescale 1ns / 1ps
`default_nettype none

module sgah_close #(
    parameter int VALUE_COLUMNS = 3
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire  [31:0]               key,
    input  wire  [31:0]               count,
    input  sgah_pkg::lane_agg_t       lane_agg [VALUE_COLUMNS],
    input  sgah_pkg::cfg_t            cfg,
    output logic                      idle,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    output logic [63:0]               m_axis_tdata
);
    import sgah_pkg::*;

    localparam int NUM_OPND = 3;
    localparam logic [1:0] OPND_LHS = 2'd0;
    localparam logic [1:0] OPND_RHS = 2'd1;
    localparam logic [1:0] OPND_RET = 2'd2;

    close_state_t state_reg;
    close_state_t state_next;

    logic [1:0]               idx_reg;
    logic signed [DATA_W-1:0] opv_reg [NUM_OPND];
    logic [SUM_W-1:0]         ops_reg [NUM_OPND];
    logic [NUM_OPND-1:0]      opd_reg;
    logic [DATA_W-1:0]        key_reg;
    logic [DATA_W-1:0]        cnt_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_key_reg;
    logic [DATA_W-1:0] out_val_reg;

    opnd_t       lhs_sel;
    opnd_t       rhs_sel;
    opnd_t       ret_sel;
    logic        pass;
    logic        out_free;
    logic        div_start;
    logic        load_out;
    logic        div_done;
    logic [31:0] div_quo;

    // pick one aggregate out of the lanes; columns past the lanes act as star
    function automatic opnd_t sel_agg(input logic [2:0] func, input logic [2:0] col);
        opnd_t                    r;
        logic [SUM_W-1:0]         s;
        logic signed [DATA_W-1:0] mn;
        logic signed [DATA_W-1:0] mx;
        s  = '0;
        mn = INT_MAX;
        mx = INT_MIN;
        for (int c = 0; c < VALUE_COLUMNS; c++)
        begin
            if (col == 3'(c))
            begin
                s  = lane_agg[c].sum;
                mn = lane_agg[c].mn;
                mx = lane_agg[c].mx;
            end
        end
        r.val = '0;
        r.sum = s;
        r.div = 1'b0;
        unique case (func)
            FUNC_MAX:   r.val = mx;
            FUNC_MIN:   r.val = mn;
            FUNC_COUNT: r.val = count;
            FUNC_SUM:   r.val = s[DATA_W-1:0];
            FUNC_AVG:   r.div = 1'b1;
            default:    r.val = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        lhs_sel = sel_agg(cfg.lhs_func, {1'b0, cfg.lhs_col});
        ret_sel = sel_agg(cfg.ret_func, {1'b0, cfg.ret_col});
        if (cfg.rhs_col >= RHS_CONST_COL)
        begin
            rhs_sel = '{val: cfg.rhs_value, sum: '0, div: 1'b0};
        end
        else
        begin
            rhs_sel = sel_agg(cfg.rhs_func, cfg.rhs_col);
        end
    end

    always_comb
    begin
        unique case (cfg.op)
            OP_EQ:   pass = opv_reg[OPND_LHS] == opv_reg[OPND_RHS];
            OP_NE:   pass = opv_reg[OPND_LHS] != opv_reg[OPND_RHS];
            OP_GT:   pass = opv_reg[OPND_LHS] >  opv_reg[OPND_RHS];
            OP_GE:   pass = opv_reg[OPND_LHS] >= opv_reg[OPND_RHS];
            OP_LT:   pass = opv_reg[OPND_LHS] <  opv_reg[OPND_RHS];
            OP_LE:   pass = opv_reg[OPND_LHS] <= opv_reg[OPND_RHS];
            default: pass = 1'b0;
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CL_IDLE:
            begin
                if (start)
                begin
                    state_next = CL_SCAN;
                end
            end
            CL_SCAN:
            begin
                if (opd_reg[idx_reg])
                begin
                    state_next = CL_DIV;
                end
                else if (idx_reg == OPND_RET)
                begin
                    state_next = CL_DECIDE;
                end
            end
            CL_DIV:
            begin
                if (div_done)
                begin
                    state_next = CL_SCAN;
                end
            end
            CL_DECIDE:
            begin
                if (!pass || out_free)
                begin
                    state_next = CL_IDLE;
                end
            end
            default: state_next = CL_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        idle      = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            CL_IDLE:   idle = 1'b1;
            CL_SCAN:   div_start = opd_reg[idx_reg];
            CL_DIV:    div_start = 1'b0;
            CL_DECIDE: load_out = pass && out_free;
            default:   idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CL_IDLE;
            idx_reg       <= '0;
            opd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == CL_IDLE)
            begin
                idx_reg <= OPND_LHS;
                opd_reg <= {ret_sel.div, rhs_sel.div, lhs_sel.div};
            end
            else if (state_reg == CL_SCAN && !opd_reg[idx_reg] && idx_reg != OPND_RET)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == CL_DIV && div_done)
            begin
                opd_reg[idx_reg] <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == CL_IDLE)
        begin
            key_reg           <= key;
            cnt_reg           <= count;
            opv_reg[OPND_LHS] <= lhs_sel.val;
            opv_reg[OPND_RHS] <= rhs_sel.val;
            opv_reg[OPND_RET] <= ret_sel.val;
            ops_reg[OPND_LHS] <= lhs_sel.sum;
            ops_reg[OPND_RHS] <= rhs_sel.sum;
            ops_reg[OPND_RET] <= ret_sel.sum;
        end
        else if (state_reg == CL_DIV && div_done)
        begin
            opv_reg[idx_reg] <= div_quo;
        end

        if (load_out)
        begin
            out_key_reg <= key_reg;
            out_val_reg <= opv_reg[OPND_RET];
        end
    end

    sgah_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ops_reg[idx_reg]),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_val_reg, out_key_reg};

endmodule

`default_nettype wire

[rtl/sorted_group_aggregate_having.sv]
// sorted group-by aggregation with a HAVING filter
// rows of one group are taken one per cycle while the close unit is idle; a beat
// that closes a group holds off input while the close unit scans the operands, runs
// the shared serial divider for each AVG operand and loads a passing result, and longer
// while that result waits on a full, stalled output register
// reset clears the open group, the configuration and the output register
`timescale 1ns / 1ps
`default_nettype none

module sorted_group_aggregate_having #(
    parameter int VALUE_COLUMNS = 3
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [2:0]   cfg_index,
    input  wire  [31:0]  cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [127:0] s_axis_tdata,   // group_key, value_a, value_b, value_c
    input  wire          s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [63:0]  m_axis_tdata    // out_key, result_value
);
    import sgah_pkg::*;

    cfg_t              cfg_reg;
    logic              have_group_reg;
    logic [DATA_W-1:0] current_key_reg;
    logic [DATA_W-1:0] row_count_reg;

    logic              accept;
    logic              is_eos;
    logic [DATA_W-1:0] key_in;
    logic              key_diff;
    logic              new_group;
    logic              closing;
    lane_ctl_t         lane_ctl;
    lane_agg_t         lane_agg [VALUE_COLUMNS];
    logic              close_idle;

    assign key_in    = s_axis_tdata[DATA_W-1:0];
    assign is_eos    = s_axis_tuser;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign key_diff  = key_in != current_key_reg;
    assign new_group = !have_group_reg || key_diff;
    assign closing   = accept && have_group_reg && (is_eos || key_diff);

    assign lane_ctl.clear = accept && (is_eos || new_group);
    assign lane_ctl.acc   = accept && !is_eos;

    assign s_axis_tready = close_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{lhs_func: FUNC_MAX, lhs_col: '0, op: OP_EQ, rhs_func: FUNC_MAX,
                         rhs_col: RHS_CONST_COL, rhs_value: '0, ret_func: FUNC_MAX,
                         ret_col: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LHS_FUNC:  cfg_reg.lhs_func  <= cfg_data[2:0];
                CFG_LHS_COL:   cfg_reg.lhs_col   <= cfg_data[1:0];
                CFG_OP:        cfg_reg.op        <= cfg_data[2:0];
                CFG_RHS_FUNC:  cfg_reg.rhs_func  <= cfg_data[2:0];
                CFG_RHS_COL:   cfg_reg.rhs_col   <= cfg_data[2:0];
                CFG_RHS_VALUE: cfg_reg.rhs_value <= cfg_data;
                CFG_RET_FUNC:  cfg_reg.ret_func  <= cfg_data[2:0];
                CFG_RET_COL:   cfg_reg.ret_col   <= cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_group_reg  <= 1'b0;
            current_key_reg <= '0;
            row_count_reg   <= '0;
        end
        else if (accept)
        begin
            if (is_eos)
            begin
                have_group_reg <= 1'b0;
                row_count_reg  <= '0;
            end
            else if (new_group)
            begin
                have_group_reg  <= 1'b1;
                current_key_reg <= key_in;
                row_count_reg   <= DATA_W'(1);
            end
            else
            begin
                row_count_reg <= row_count_reg + 1'b1;
            end
        end
    end

    // one lane per value column; columns without an input field stay empty
    for (genvar c = 0; c < VALUE_COLUMNS; c++)
    begin : g_lane
        if (c < IN_COLUMNS)
        begin : g_fed
            sgah_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (lane_ctl),
                .value (s_axis_tdata[DATA_W*(c+1) +: DATA_W]),
                .agg   (lane_agg[c])
            );
        end
        else
        begin : g_empty
            sgah_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   ('0),
                .value ('0),
                .agg   (lane_agg[c])
            );
        end
    end

    sgah_close #(
        .VALUE_COLUMNS (VALUE_COLUMNS)
    ) u_close (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (closing),
        .key           (current_key_reg),
        .count         (row_count_reg),
        .lane_agg      (lane_agg),
        .cfg           (cfg_reg),
        .idle          (close_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[tb/group_result_checker.sv]
// watches the config port and both stream channels of sorted_group_aggregate_having
// keeps its own group aggregates and HAVING settings, predicts each result beat and compares
// depends on sgah_pkg for codes and the config struct
`timescale 1ns / 1ps

module group_result_checker #(
    parameter int VALUE_COLUMNS = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [2:0]   cfg_index,
    input  wire [31:0]  cfg_data,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire [127:0] s_axis_tdata,   // group_key, value_a, value_b, value_c
    input  wire         s_axis_tuser,   // cmd
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [63:0]  m_axis_tdata,   // out_key, result_value
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import sgah_pkg::*;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } group_result_t;

    group_result_t      awaited_q[$];
    cfg_t               having_cfg;
    logic               grp_open;
    logic [31:0]        grp_key;
    logic [31:0]        grp_rows;
    logic [63:0]        col_sum [4];
    logic signed [31:0] col_min [4];
    logic signed [31:0] col_max [4];
    int                 mismatches;
    int                 matched;

    function automatic logic [31:0] mean_of(logic [63:0] total, logic [31:0] cnt);
        logic [63:0] mag;
        logic [63:0] quot;
        if (cnt == 32'd0)
            return 32'd0;
        mag  = total[63] ? (64'd0 - total) : total;
        quot = mag / {32'd0, cnt};
        if (total[63])
            quot = 64'd0 - quot;
        return quot[31:0];
    endfunction

    // columns at or past VALUE_COLUMNS behave as the star column
    function automatic logic [31:0] aggregate_of(logic [2:0] func, logic [2:0] col);
        logic        star;
        logic [63:0] total;
        logic [31:0] lo;
        logic [31:0] hi;
        star  = (col >= VALUE_COLUMNS);
        total = star ? 64'd0 : col_sum[col[1:0]];
        lo    = star ? INT_MAX : col_min[col[1:0]];
        hi    = star ? INT_MIN : col_max[col[1:0]];
        case (func)
            FUNC_MAX:   return hi;
            FUNC_MIN:   return lo;
            FUNC_COUNT: return grp_rows;
            FUNC_SUM:   return total[31:0];
            FUNC_AVG:   return mean_of(total, grp_rows);
            default:    return 32'd0;
        endcase
    endfunction

    function automatic logic having_holds(logic signed [31:0] lhs, logic signed [31:0] rhs,
                                          logic [2:0] op);
        case (op)
            OP_EQ:   return lhs == rhs;
            OP_NE:   return lhs != rhs;
            OP_GT:   return lhs > rhs;
            OP_GE:   return lhs >= rhs;
            OP_LT:   return lhs < rhs;
            OP_LE:   return lhs <= rhs;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_group();
        int c;
        grp_rows = 32'd0;
        for (c = 0; c < 4; c++)
        begin
            col_sum[c] = 64'd0;
            col_min[c] = INT_MAX;
            col_max[c] = INT_MIN;
        end
    endtask

    task automatic close_group();
        logic [31:0]   lhs;
        logic [31:0]   rhs;
        group_result_t res;
        if (grp_open)
        begin
            lhs = aggregate_of(having_cfg.lhs_func, {1'b0, having_cfg.lhs_col});
            rhs = (having_cfg.rhs_col >= RHS_CONST_COL) ? having_cfg.rhs_value
                : aggregate_of(having_cfg.rhs_func, having_cfg.rhs_col);
            if (having_holds(lhs, rhs, having_cfg.op))
            begin
                res.key   = grp_key;
                res.value = aggregate_of(having_cfg.ret_func, {1'b0, having_cfg.ret_col});
                awaited_q.insert(awaited_q.size(), res);
            end
        end
    endtask

    task automatic take_beat(logic cmd, logic [127:0] data);
        logic [31:0]        key;
        logic signed [31:0] v;
        int                 c;
        key = data[31:0];
        if (cmd)
        begin
            close_group();
            grp_open = 1'b0;
            clear_group();
        end
        else
        begin
            if (!grp_open || key != grp_key)
            begin
                close_group();
                clear_group();
                grp_key  = key;
                grp_open = 1'b1;
            end
            for (c = 0; c < VALUE_COLUMNS && c < IN_COLUMNS; c++)
            begin
                v = data[32*(c+1) +: 32];
                col_sum[c] = col_sum[c] + {{32{v[31]}}, v};
                if (v < col_min[c])
                    col_min[c] = v;
                if (v > col_max[c])
                    col_max[c] = v;
            end
            grp_rows = grp_rows + 32'd1;
        end
    endtask

    task automatic check_result(logic [63:0] data);
        group_result_t got;
        group_result_t want;
        got.key   = data[31:0];
        got.value = data[63:32];
        if (awaited_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: key=%0d value=%0d",
                         $signed(got.key), $signed(got.value));
        end
        else
        begin
            want = awaited_q.pop_front();
            if (want.key !== got.key || want.value !== got.value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected key=%0d value=%0d, got key=%0d value=%0d",
                             $signed(want.key), $signed(want.value),
                             $signed(got.key), $signed(got.value));
            end
            else
                matched++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            having_cfg         = '0;
            having_cfg.rhs_col = RHS_CONST_COL;
            grp_open           = 1'b0;
            grp_key            = 32'd0;
            clear_group();
            awaited_q.delete();
            mismatches         = 0;
            matched            = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LHS_FUNC:  having_cfg.lhs_func  = cfg_data[2:0];
                    CFG_LHS_COL:   having_cfg.lhs_col   = cfg_data[1:0];
                    CFG_OP:        having_cfg.op        = cfg_data[2:0];
                    CFG_RHS_FUNC:  having_cfg.rhs_func  = cfg_data[2:0];
                    CFG_RHS_COL:   having_cfg.rhs_col   = cfg_data[2:0];
                    CFG_RHS_VALUE: having_cfg.rhs_value = cfg_data;
                    CFG_RET_FUNC:  having_cfg.ret_func  = cfg_data[2:0];
                    CFG_RET_COL:   having_cfg.ret_col   = cfg_data[1:0];
                    default:       ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_beat(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            fail_count   <= mismatches;
            pending      <= awaited_q.size();
            results_seen <= matched;
        end
    end

endmodule

[tb/tb_top.sv]
// top of the sorted_group_aggregate_having testbench: clock, reset, row stimulus,
// register settings and random back-pressure; the verdict comes from group_result_checker
// depends on sgah_pkg, the block and tb/group_result_checker.sv
`timescale 1ns / 1ps

module tb_top;

    import sgah_pkg::*;

    localparam int VALUE_COLUMNS = 3;
    localparam int CYCLE_LIMIT   = 1_500_000;
    // closing beat waits on the divider for each AVG operand, three operands at most
    localparam int DRAIN_CYCLES  = 300;
    localparam int PHASES        = 10;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // group_key, value_a, value_b, value_c
    logic         s_axis_tuser;   // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // out_key, result_value

    int           fail_count;
    int           pending;
    int           results_seen;
    int           cycles = 0;
    int           beats = 0;
    int           end_marks = 0;
    int           settings = 0;
    logic         no_gaps = 1'b0;
    logic [31:0]  last_key = 32'd0;
    logic [31:0]  prior_key = 32'd0;

    sorted_group_aggregate_having #(
        .VALUE_COLUMNS (VALUE_COLUMNS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    group_result_checker #(
        .VALUE_COLUMNS (VALUE_COLUMNS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_group_aggregate_having test failed");
            $finish;
        end
    end

    // result sink: per beat a random stall once the beat shows up
    initial
    begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
                while (!m_axis_tvalid)
                    @(posedge clk);
                repeat (gap - 1) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return INT_MAX;
            1:       return INT_MIN;
            2:       return 32'd0;
            3, 4:    return $urandom_range(0, 32) - 16;
            default: return $urandom();
        endcase
    endfunction

    // mostly ascending keys, now and then a jump, an extreme or a key seen before
    function automatic logic [31:0] next_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:       k = $urandom();
            1:       k = $urandom_range(0, 1) ? INT_MAX : INT_MIN;
            2:       k = prior_key;
            default: k = last_key + $urandom_range(1, 4);
        endcase
        prior_key = last_key;
        last_key  = k;
        return k;
    endfunction

    // unused upper bits of a narrow register get random junk
    function automatic logic [31:0] pad_junk(logic [31:0] v, int w);
        return ($urandom() << w) | v;
    endfunction

    task automatic send_beat(logic cmd, logic [31:0] key, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a, key};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats++;
        if (cmd)
            end_marks++;
    endtask

    task automatic send_end_mark();
        send_beat(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic write_config(logic [2:0] lhs_func, logic [1:0] lhs_col, logic [2:0] op,
                                logic [2:0] rhs_func, logic [2:0] rhs_col,
                                logic [31:0] rhs_value, logic [2:0] ret_func,
                                logic [1:0] ret_col);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LHS_FUNC;
        cfg_data  <= pad_junk({29'd0, lhs_func}, 3);
        @(posedge clk);
        cfg_index <= CFG_LHS_COL;
        cfg_data  <= pad_junk({30'd0, lhs_col}, 2);
        @(posedge clk);
        cfg_index <= CFG_OP;
        cfg_data  <= pad_junk({29'd0, op}, 3);
        @(posedge clk);
        cfg_index <= CFG_RHS_FUNC;
        cfg_data  <= pad_junk({29'd0, rhs_func}, 3);
        @(posedge clk);
        cfg_index <= CFG_RHS_COL;
        cfg_data  <= pad_junk({29'd0, rhs_col}, 3);
        @(posedge clk);
        cfg_index <= CFG_RHS_VALUE;
        cfg_data  <= rhs_value;
        @(posedge clk);
        cfg_index <= CFG_RET_FUNC;
        cfg_data  <= pad_junk({29'd0, ret_func}, 3);
        @(posedge clk);
        cfg_index <= CFG_RET_COL;
        cfg_data  <= pad_junk({30'd0, ret_col}, 2);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // wait for every predicted result, then let a silent close run out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int target);
        int          sent;
        int          rows;
        int          r;
        logic [31:0] key;
        sent = 0;
        while (sent < target)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            key     = next_key();
            rows    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            for (r = 0; r < rows; r++)
                send_beat(1'b0, key, pick_value(), pick_value(), pick_value());
            sent += rows;
            if ($urandom_range(0, 7) == 0)
            begin
                send_end_mark();
                sent++;
                // end marker with nothing open
                if ($urandom_range(0, 3) == 0)
                begin
                    send_end_mark();
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
        send_end_mark();
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_LHS_FUNC;
        cfg_data      <= 32'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings after reset: MAX(a) == 0, return MAX(a)
        send_end_mark();
        send_beat(1'b0, INT_MIN, 32'd0, INT_MAX, INT_MIN);
        send_beat(1'b0, INT_MIN, -32'sd5, INT_MIN, INT_MAX);
        send_beat(1'b0, INT_MAX, INT_MAX, INT_MIN, 32'd0);
        send_end_mark();
        send_end_mark();
        settle();

        // COUNT(*) >= 1 always holds; AVG(b) rounds toward zero
        write_config(FUNC_COUNT, 2'd3, OP_GE, FUNC_MAX, RHS_CONST_COL, 32'd1, FUNC_AVG, 2'd1);
        send_beat(1'b0, 32'd7, pick_value(), INT_MIN, pick_value());
        send_beat(1'b0, 32'd7, pick_value(), INT_MIN, pick_value());
        send_beat(1'b0, 32'd7, pick_value(), INT_MAX, pick_value());
        send_beat(1'b0, -32'sd1, pick_value(), -32'sd7, pick_value());
        send_beat(1'b0, -32'sd1, pick_value(), 32'd2, pick_value());
        send_beat(1'b0, 32'd0, pick_value(), INT_MAX, pick_value());
        send_end_mark();
        settle();

        // SUM(c) > MIN(a), return MIN(*); same key again after an end marker
        write_config(FUNC_SUM, 2'd2, OP_GT, FUNC_MIN, 3'd0, INT_MIN, FUNC_MIN, 2'd3);
        send_beat(1'b0, 32'd5, 32'd3, pick_value(), 32'd10);
        send_end_mark();
        send_beat(1'b0, 32'd5, INT_MAX, pick_value(), INT_MIN);
        send_beat(1'b0, 32'd5, -32'sd1, pick_value(), INT_MIN);
        send_beat(1'b0, 32'd6, 32'd0, pick_value(), 32'd0);
        send_end_mark();
        send_end_mark();
        settle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                // three AVG operands keep the divider busiest
                0: write_config(FUNC_AVG, 2'd0, OP_LT, FUNC_AVG, 3'd1, pick_value(),
                                FUNC_AVG, 2'd2);
                // unknown function codes give zero and the right side is the constant zero, so every group passes
                1: write_config(3'd7, 2'd1, OP_EQ, 3'd5, 3'd7, 32'd0, 3'd6, 2'd3);
                2: write_config(FUNC_COUNT, 2'd3, 3'd7, FUNC_SUM, 3'd2, pick_value(),
                                FUNC_SUM, 2'd1);
                3: write_config(FUNC_MIN, 2'd3, OP_GE, FUNC_MAX, RHS_CONST_COL, INT_MAX,
                                FUNC_MAX, 2'd3);
                4: write_config(FUNC_MAX, 2'd2, OP_GE, FUNC_MIN, 3'd2, 32'd0, FUNC_SUM, 2'd0);
                5: write_config(FUNC_SUM, 2'd1, OP_LE, FUNC_AVG, 3'd3, INT_MIN,
                                FUNC_COUNT, 2'd3);
                6: write_config(FUNC_MAX, 2'd0, 3'd6, FUNC_MIN, RHS_CONST_COL, INT_MIN,
                                FUNC_MIN, 2'd0);
                7: write_config(FUNC_AVG, 2'd3, OP_NE, FUNC_SUM, 3'd3, INT_MIN, FUNC_AVG, 2'd1);
                default: write_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                      3'($urandom_range(0, 5)), 3'($urandom_range(0, 7)),
                                      3'($urandom_range(0, 7)), pick_value(),
                                      3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
            endcase
            // phases with a never-true compare stay short
            run_phase((phase == 2 || phase == 6) ? 40 : 180);
            settle();
        end

        $display("drove %0d row and end-of-stream beats (%0d end markers) under %0d HAVING setups",
                 beats, end_marks, settings);
        $display("%0d group results matched, %0d failures counted", results_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("sorted_group_aggregate_having test passed");
        else
            $display("sorted_group_aggregate_having test failed");
        $finish;
    end

endmodule
